// ===== rtl/recursive_mutex_with_wait_fifo_defines.svh =====
// Assertion macros shared by the lock's RTL files.
`ifndef RECURSIVE_MUTEX_WITH_WAIT_FIFO_DEFINES_SVH
`define RECURSIVE_MUTEX_WITH_WAIT_FIFO_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define RMWF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define RMWF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RMWF_ASSERT(lbl, clk, rst_n, prop, msg)
`define RMWF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/rmwf_pkg.sv =====
package rmwf_pkg;

  // Field widths of the request and result items
  localparam int KIND_W   = 1;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 4;
  localparam int OWNER_W  = 8;
  localparam int NEST_W   = 16;

  // Defaults of the top-level parameters
  localparam int WAIT_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF    = 8;
  localparam int COUNT_BITS_DEF = 16;

  // Request kinds
  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 4'd0,
    ST_NESTED      = 4'd1,
    ST_QUEUED      = 4'd2,
    ST_REL_NESTED  = 4'd3,
    ST_FREED       = 4'd4,
    ST_HANDED_OVER = 4'd5,
    ST_NOT_HOLDER  = 4'd6,
    ST_QUEUE_FULL  = 4'd7,
    ST_COUNT_OVF   = 4'd8
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

// ===== rtl/rmwf_req_if.sv =====
interface rmwf_req_if;
  import rmwf_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  thread_id;

  modport source (output valid, output kind, output thread_id, input ready);
  modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

// ===== rtl/rmwf_rsp_if.sv =====
interface rmwf_rsp_if;
  import rmwf_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [OWNER_W-1:0] owner_id;
  logic               owner_valid;
  logic [NEST_W-1:0]  nest_count;

  modport source (output valid, output status, output owner_id, output owner_valid,
                  output nest_count, input ready);
  modport sink   (input valid, input status, input owner_id, input owner_valid,
                  input nest_count, output ready);
endinterface

// ===== rtl/rmwf_ctrl.sv =====
`include "recursive_mutex_with_wait_fifo_defines.svh"

module rmwf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rmwf_pkg::dp_stat_t stat,
  output rmwf_pkg::dp_cmd_t  cmd
);
  import rmwf_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance: take an item, then execute once the result register is free
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_full) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = !stat.out_full;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `RMWF_ASSERT(a_accept_to_exec, clk, rst_n,
    (state_r == S_IDLE && in_valid) |=> (state_r == S_EXEC), "accepted item not executed")
  `RMWF_ASSERT(a_exec_to_idle, clk, rst_n,
    cmd.exec |=> (state_r == S_IDLE && in_ready), "no return to idle after execute")
  `RMWF_ASSERT_NEVER(a_exec_blocked, clk, rst_n,
    cmd.exec && stat.out_full, "execute while result register is full")

endmodule

// ===== rtl/rmwf_dp.sv =====
`include "recursive_mutex_with_wait_fifo_defines.svh"

module rmwf_dp #(
  parameter int WAIT_DEPTH = rmwf_pkg::WAIT_DEPTH_DEF,
  parameter int ID_BITS    = rmwf_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = rmwf_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmwf_pkg::dp_cmd_t             cmd,
  output rmwf_pkg::dp_stat_t            stat,
  input  logic [rmwf_pkg::KIND_W-1:0]   in_kind,
  input  logic [rmwf_pkg::TID_W-1:0]    in_thread_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rmwf_pkg::status_t             out_status,
  output logic [rmwf_pkg::OWNER_W-1:0]  out_owner_id,
  output logic                          out_owner_valid,
  output logic [rmwf_pkg::NEST_W-1:0]   out_nest_count
);
  import rmwf_pkg::*;

  localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int USED_W = $clog2(WAIT_DEPTH + 1);
  localparam logic [PTR_W-1:0]      PTR_LAST  = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [USED_W-1:0]     USED_FULL = USED_W'(WAIT_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Lock state
  logic [ID_BITS-1:0]    holder_r, holder_nxt;
  logic                  held_r, held_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;

  // Waiter queue storage and its registered head read
  logic [ID_BITS-1:0] wait_mem [WAIT_DEPTH];
  logic [ID_BITS-1:0] head_id_r;

  // Captured request
  logic               rel_r;
  logic [ID_BITS-1:0] tid_r;

  // Result register
  logic               out_full_r;
  status_t            status_r, status_nxt;
  logic [OWNER_W-1:0] owner_r;
  logic               owner_vld_r;
  logic [NEST_W-1:0]  nest_r;

  logic        push;
  logic [15:0] tid_ext;
  logic [15:0] holder_ext;
  logic [31:0] count_ext;

  assign tid_ext = 16'(in_thread_id);

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rel_r <= in_kind[0];
      tid_r <= tid_ext[ID_BITS-1:0];
    end
  end

  // Decide the request against the current lock state
  always_comb begin
    holder_nxt = holder_r;
    held_nxt   = held_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    used_nxt   = used_r;
    push       = 1'b0;
    status_nxt = ST_NOT_HOLDER;
    if (rel_r == KIND_ACQUIRE) begin
      if (!held_r) begin
        held_nxt   = 1'b1;
        holder_nxt = tid_r;
        count_nxt  = COUNT_ONE;
        status_nxt = ST_GRANTED;
      end else if (holder_r == tid_r) begin
        if (count_r == COUNT_MAX) begin
          status_nxt = ST_COUNT_OVF;
        end else begin
          count_nxt  = count_r + COUNT_ONE;
          status_nxt = ST_NESTED;
        end
      end else if (used_r == USED_FULL) begin
        status_nxt = ST_QUEUE_FULL;
      end else begin
        push       = 1'b1;
        tail_nxt   = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
        used_nxt   = used_r + USED_W'(1);
        status_nxt = ST_QUEUED;
      end
    end else begin
      if (!held_r || holder_r != tid_r) begin
        status_nxt = ST_NOT_HOLDER;
      end else if (count_r > COUNT_ONE) begin
        count_nxt  = count_r - COUNT_ONE;
        status_nxt = ST_REL_NESTED;
      end else if (used_r != '0) begin
        holder_nxt = head_id_r;
        head_nxt   = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
        used_nxt   = used_r - USED_W'(1);
        count_nxt  = COUNT_ONE;
        status_nxt = ST_HANDED_OVER;
      end else begin
        held_nxt   = 1'b0;
        holder_nxt = '0;
        count_nxt  = '0;
        status_nxt = ST_FREED;
      end
    end
  end

  // Commit the lock state on execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holder_r <= '0;
      held_r   <= 1'b0;
      count_r  <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      used_r   <= '0;
    end else if (cmd.exec) begin
      holder_r <= holder_nxt;
      held_r   <= held_nxt;
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      used_r   <= used_nxt;
    end
  end

  // Write a waiter at the tail, read the head every cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && push) wait_mem[tail_r] <= tid_r;
    head_id_r <= wait_mem[head_r];
  end

  assign holder_ext = 16'(holder_nxt);
  assign count_ext  = 32'(count_nxt);

  // Load the result; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (cmd.exec) begin
      out_full_r <= 1'b1;
    end else if (out_ready) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r    <= status_nxt;
      owner_r     <= holder_ext[OWNER_W-1:0];
      owner_vld_r <= held_nxt;
      nest_r      <= count_ext[NEST_W-1:0];
    end
  end

  assign stat.out_full   = out_full_r && !out_ready;
  assign out_valid       = out_full_r;
  assign out_status      = status_r;
  assign out_owner_id    = owner_r;
  assign out_owner_valid = owner_vld_r;
  assign out_nest_count  = nest_r;

  `RMWF_ASSERT_NEVER(a_used_range, clk, rst_n,
    used_r > USED_FULL, "waiter count beyond queue depth")
  `RMWF_ASSERT(a_free_clean, clk, rst_n,
    !held_r |-> (count_r == '0 && holder_r == '0), "free lock keeps holder or count")
  `RMWF_ASSERT(a_held_count, clk, rst_n,
    held_r |-> (count_r != '0), "held lock with zero count")
  `RMWF_ASSERT(a_free_no_waiters, clk, rst_n,
    (cmd.exec && !held_r && used_r != '0) |-> 1'b0, "waiters queued on a free lock")

endmodule

// ===== rtl/recursive_mutex_with_wait_fifo.sv =====
// Recursive mutex with a first-in first-out queue of waiting threads.
// in_ch carries requests: kind (0 acquire, 1 release) and thread_id; the low
// ID_BITS bits of thread_id name the thread. out_ch returns exactly one result
// item per request: status code, owner_id, owner_valid and nest_count after it.
// Both channels move an item at a rising edge where valid and ready are high.
// A taken request is captured, then executed into the result register once
// that register is free. The queue's head entry comes from a registered memory
// read that must follow any push or pop of the previous item, so each item
// passes an accept state and then an execute state before the next is taken.
// A finished result sits in an output register; the next request is taken
// while it waits. If out_ch stalls, the following request waits in its
// execute cycle and in_ch ready stays low until the result register frees.
// Reset (rst_n low, synchronous) frees the lock, empties the waiter queue and
// drops any pending result; queue storage needs no clearing.
module recursive_mutex_with_wait_fifo #(
  parameter int WAIT_DEPTH = rmwf_pkg::WAIT_DEPTH_DEF,
  parameter int ID_BITS    = rmwf_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = rmwf_pkg::COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rmwf_req_if.sink  in_ch,
  rmwf_rsp_if.source out_ch
);
  import rmwf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each item
  rmwf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Lock state, waiter queue and result register
  rmwf_dp #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_ch.kind),
    .in_thread_id    (in_ch.thread_id),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_owner_id    (out_ch.owner_id),
    .out_owner_valid (out_ch.owner_valid),
    .out_nest_count  (out_ch.nest_count)
  );

endmodule
